### sv/tsb_pkg.sv
// Shared types and constants for the timestamped sample slot buffer.
// No dependencies; imported by the top level and the slot memory.
package tsb_pkg;

  localparam int unsigned SlotCountDef = 16;

  typedef enum logic [1:0] {
    OpStore = 2'd0,
    OpRead  = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StZeroStamp = 2'd1,
    StFull      = 2'd2,
    StRange     = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] time_stamp;
    logic [31:0] sample_value;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_used;
    logic [31:0] read_value;
    logic [31:0] read_stamp;
    logic        next_found;
    logic [3:0]  next_index;
    logic [4:0]  occupied_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] stamp;
  } slot_t;

endpackage

### sv/timestamped_sample_slot_buffer_top.sv
// Top level of the timestamped sample slot buffer: request decode and result.
// Depends on tsb_pkg, tsb_slot_mem and tsb_occ.
//
// Each item is accepted at a clock edge where start is high and busy is low;
// busy then goes high while the registered slot memory read completes, and
// the result appears with done_o while busy is high. Because busy stays high
// until the result is shown, the block cannot accept a new item before it is
// through with the last one. The result is shown for exactly
// one cycle and must be taken then; the receiver cannot stall the block.
// Occupancy lives in one flop per slot, so reset leaves every slot free at
// once with no clearing pass.
module timestamped_sample_slot_buffer_top #(
  parameter int unsigned SLOT_COUNT = tsb_pkg::SlotCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  tsb_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output tsb_pkg::rsp_t rsp_o
);
  import tsb_pkg::*;

  localparam int unsigned AddrW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned IdxW   = (AddrW > 4) ? AddrW : 4;
  localparam int unsigned CountW = $clog2(SLOT_COUNT + 1);

  logic                  accept;
  logic [IdxW-1:0]       idx_ext;
  logic [AddrW-1:0]      addr;
  logic                  in_range;

  logic [SLOT_COUNT-1:0] occ;
  logic                  full;
  logic [AddrW-1:0]      free_idx;
  logic                  any_occ;
  logic [AddrW-1:0]      first_idx;
  logic [CountW-1:0]     count;

  logic                  occ_set, occ_clr, mem_we, mem_re;
  logic [AddrW-1:0]      occ_idx;
  slot_t                 wdata, rdata;

  status_e               status_d, status_q;
  logic [3:0]            used_d, used_q;
  logic                  rd_d, rd_q;
  logic                  pend_q;

  assign accept   = start && !busy;
  assign idx_ext  = IdxW'(req_i.slot_index);
  assign addr     = idx_ext[AddrW-1:0];
  assign in_range = 32'(req_i.slot_index) < SLOT_COUNT;

  assign wdata.value = req_i.sample_value;
  assign wdata.stamp = req_i.time_stamp;

  always_comb begin
    status_d = StOk;
    used_d   = '0;
    rd_d     = 1'b0;
    occ_set  = 1'b0;
    occ_clr  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    occ_idx  = addr;
    unique case (req_i.op)
      OpStore: begin
        occ_idx = free_idx;
        if (req_i.time_stamp == '0) begin
          status_d = StZeroStamp;
        end else if (full) begin
          status_d = StFull;
        end else begin
          used_d  = 4'(free_idx);
          occ_set = accept;
          mem_we  = accept;
        end
      end
      OpRead: begin
        used_d = req_i.slot_index;
        if (!in_range) begin
          status_d = StRange;
        end else begin
          rd_d   = occ[addr];
          mem_re = accept;
        end
      end
      OpClear: begin
        used_d = req_i.slot_index;
        if (!in_range) begin
          status_d = StRange;
        end else begin
          occ_clr = accept;
        end
      end
      default: begin
      end
    endcase
  end

  tsb_occ #(
    .SlotCount (SLOT_COUNT),
    .AddrW     (AddrW),
    .CountW    (CountW)
  ) u_occ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (occ_set),
    .clr_i       (occ_clr),
    .idx_i       (occ_idx),
    .occ_o       (occ),
    .full_o      (full),
    .free_idx_o  (free_idx),
    .any_o       (any_occ),
    .first_idx_o (first_idx),
    .count_o     (count)
  );

  tsb_slot_mem #(
    .SlotCount (SLOT_COUNT),
    .AddrW     (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      used_q   <= used_d;
      rd_q     <= rd_d;
    end
  end

  assign busy   = pend_q;
  assign done_o = pend_q;

  assign rsp_o.status         = status_q;
  assign rsp_o.slot_used      = used_q;
  assign rsp_o.read_value     = rd_q ? rdata.value : '0;
  assign rsp_o.read_stamp     = rd_q ? rdata.stamp : '0;
  assign rsp_o.next_found     = any_occ;
  assign rsp_o.next_index     = 4'(first_idx);
  assign rsp_o.occupied_count = 5'(count);

endmodule

### sv/tsb_slot_mem.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on tsb_pkg for the slot word type.
module tsb_slot_mem #(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned AddrW     = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  tsb_pkg::slot_t    wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output tsb_pkg::slot_t    rdata_o
);
  import tsb_pkg::*;

  slot_t mem [SlotCount];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tsb_occ.sv
// Occupancy tracker: one flop per slot, occupied count, lowest free and
// lowest occupied slot. Depends on no package items.
module tsb_occ #(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned AddrW     = 4,
  parameter int unsigned CountW    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              set_i,
  input  logic              clr_i,
  input  logic [AddrW-1:0]  idx_i,
  output logic [SlotCount-1:0] occ_o,
  output logic              full_o,
  output logic [AddrW-1:0]  free_idx_o,
  output logic              any_o,
  output logic [AddrW-1:0]  first_idx_o,
  output logic [CountW-1:0] count_o
);

  logic [SlotCount-1:0] occ_q, occ_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 drop;

  assign drop = clr_i && occ_q[idx_i];

  always_comb begin
    occ_d   = occ_q;
    count_d = count_q;
    if (set_i) begin
      occ_d[idx_i] = 1'b1;
      count_d      = count_q + CountW'(1);
    end else if (drop) begin
      occ_d[idx_i] = 1'b0;
      count_d      = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      count_q <= '0;
    end else begin
      occ_q   <= occ_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    free_idx_o  = '0;
    first_idx_o = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!occ_q[i]) begin
        free_idx_o = AddrW'(i);
      end
      if (occ_q[i]) begin
        first_idx_o = AddrW'(i);
      end
    end
  end

  assign full_o  = &occ_q;
  assign any_o   = |occ_q;
  assign occ_o   = occ_q;
  assign count_o = count_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for timestamped_sample_slot_buffer_top.
// Runs directed and random store, read and clear items against an in-bench slot table.
// Depends on tsb_pkg and the block's RTL; needs no files or arguments.
module testbench;
  import tsb_pkg::*;

  localparam int unsigned Slots = SlotCountDef;
  localparam int unsigned IdleLimit = 200;
  localparam int unsigned PrintLimit = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done_o;
  rsp_t rsp;

  logic [31:0] slot_value [Slots];
  logic [31:0] slot_stamp [Slots];
  rsp_t        expected_rsp [$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 18;
  int unsigned status_hits [4] = '{default: 0};

  always #5 clk_i = ~clk_i;

  timestamped_sample_slot_buffer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp)
  );

  function automatic rsp_t predict_slot_result(req_t r);
    rsp_t        p;
    logic        placed;
    logic        any;
    int unsigned n;
    p = '0;
    placed = 1'b0;
    any = 1'b0;
    n = 0;
    p.status = StOk;
    case (r.op)
      OpStore: begin
        if (r.time_stamp == '0) begin
          p.status = StZeroStamp;
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (!placed && slot_stamp[i] == '0) begin
              slot_value[i] = r.sample_value;
              slot_stamp[i] = r.time_stamp;
              p.slot_used = 4'(i);
              placed = 1'b1;
            end
          end
          if (!placed) p.status = StFull;
        end
      end
      OpRead, OpClear: begin
        p.slot_used = r.slot_index;
        if (r.slot_index >= Slots) begin
          p.status = StRange;
        end else if (r.op == OpRead) begin
          p.read_value = slot_value[r.slot_index];
          p.read_stamp = slot_stamp[r.slot_index];
        end else begin
          slot_value[r.slot_index] = '0;
          slot_stamp[r.slot_index] = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < Slots; i++) begin
      if (slot_stamp[i] != '0) begin
        if (!any) p.next_index = 4'(i);
        any = 1'b1;
        n++;
      end
    end
    p.next_found = any;
    p.occupied_count = 5'(n);
    return p;
  endfunction

  function automatic req_t make_req(op_e op, logic [31:0] stamp, logic [31:0] value,
                                    logic [3:0] idx);
    req_t r;
    r.op = op;
    r.time_stamp = stamp;
    r.sample_value = value;
    r.slot_index = idx;
    return r;
  endfunction

  function automatic req_t random_req(int unsigned store_pct, int unsigned clear_pct);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.sample_value = $urandom;
    r.slot_index = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0: r.time_stamp = '0;
      1: r.time_stamp = '1;
      2: r.time_stamp = 32'd1;
      default: r.time_stamp = $urandom;
    endcase
    if (pick < store_pct) r.op = OpStore;
    else if (pick < store_pct + clear_pct) r.op = OpClear;
    else if (pick < 95) r.op = OpRead;
    else r.op = OpNone;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PrintLimit) begin
      $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_item(req_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsp.push_back(predict_slot_result(r));
    items_sent++;
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      status_hits[rsp.status]++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp.status), '0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.slot_used !== want.slot_used)
          report_mismatch("slot_used", 32'(rsp.slot_used), 32'(want.slot_used));
        if (rsp.read_value !== want.read_value)
          report_mismatch("read_value", rsp.read_value, want.read_value);
        if (rsp.read_stamp !== want.read_stamp)
          report_mismatch("read_stamp", rsp.read_stamp, want.read_stamp);
        if (rsp.next_found !== want.next_found)
          report_mismatch("next_found", 32'(rsp.next_found), 32'(want.next_found));
        if (rsp.next_index !== want.next_index)
          report_mismatch("next_index", 32'(rsp.next_index), 32'(want.next_index));
        if (rsp.occupied_count !== want.occupied_count)
          report_mismatch("occupied_count", 32'(rsp.occupied_count),
                          32'(want.occupied_count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("timeout: no item or result for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_empty_read();
    send_item(make_req(OpRead, 32'd7, 32'd9, 4'd15));
  endtask

  task automatic test_store_fill();
    send_item(make_req(OpStore, '0, 32'hDEAD_BEEF, 4'd0));
    send_item(make_req(OpStore, '1, '1, 4'd15));
    send_item(make_req(OpStore, 32'd1, '0, 4'd0));
    for (int i = 0; i < Slots - 2; i++) begin
      send_item(make_req(OpStore, $urandom | 32'd1, $urandom, 4'($urandom_range(0, 15))));
    end
    send_item(make_req(OpStore, 32'h8000_0000, 32'h1234_5678, 4'd3));
    send_item(make_req(OpStore, '0, '1, 4'd3));
  endtask

  task automatic test_read_clear();
    send_item(make_req(OpRead, '0, '0, 4'd15));
    send_item(make_req(OpClear, '0, '0, 4'd0));
    send_item(make_req(OpClear, '1, '1, 4'd0));
    send_item(make_req(OpRead, '0, '0, 4'd0));
    send_item(make_req(OpNone, '1, '1, 4'd15));
  endtask

  task automatic test_random_mixed();
    idle_pct = 18;
    repeat (200) send_item(random_req(40, 25));
  endtask

  task automatic test_random_back_to_back();
    idle_pct = 0;
    repeat (150) send_item(random_req(35, 30));
  endtask

  task automatic test_random_drain();
    idle_pct = 18;
    repeat (100) send_item(random_req(15, 60));
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_value[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_read();
    test_store_fill();
    test_read_clear();
    test_random_mixed();
    test_random_back_to_back();
    test_random_drain();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results", items_sent, results_seen);
    $display("Status mix: ok %0d, zero stamp %0d, full %0d, out of range %0d",
             status_hits[StOk], status_hits[StZeroStamp], status_hits[StFull],
             status_hits[StRange]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/tsb_pkg.sv
sv/tsb_slot_mem.sv
sv/tsb_occ.sv
sv/timestamped_sample_slot_buffer_top.sv
dv/testbench.sv
